// File: rtl/khd_pkg.sv
`timescale 1ns / 1ps
package khd_pkg;

    localparam int unsigned HASH_W    = 32;
    localparam logic [HASH_W-1:0] HASH_MULT = 32'd339;
    localparam logic [HASH_W-1:0] CHAR_BASE = 32'd97;
    localparam int unsigned CHAR_W    = 8;
    localparam int unsigned VALUE_W   = 16;
    localparam int unsigned SLOT_OUT_W = 7;

    typedef logic [1:0] cmd_t;
    localparam cmd_t CMD_LOOKUP = 2'd0;
    localparam cmd_t CMD_INSERT = 2'd1;
    localparam cmd_t CMD_CLEAR  = 2'd2;

    typedef logic [1:0] status_t;
    localparam status_t ST_OK        = 2'd0;
    localparam status_t ST_NOT_FOUND = 2'd1;
    localparam status_t ST_NO_SLOT   = 2'd2;
    localparam status_t ST_TOO_LONG  = 2'd3;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_DIV,
        S_READ,
        S_CHECK,
        S_WIPE,
        S_RESP
    } state_t;

    typedef struct packed {
        logic                  found;
        logic [VALUE_W-1:0]    value;
        logic [SLOT_OUT_W-1:0] slot;
        status_t               status;
    } result_t;

endpackage

// File: rtl/khd_word.sv
`timescale 1ns / 1ps
module khd_word
    import khd_pkg::*;
#(
    parameter int unsigned MAX_LEN = 16,
    parameter int unsigned LEN_W   = 5
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      take,
    input  logic [CHAR_W-1:0]         char_code,
    input  logic                      last,
    output logic [HASH_W-1:0]         hash_next,
    output logic [LEN_W-1:0]          fin_len,
    output logic [MAX_LEN*CHAR_W-1:0] word_chars
);
    localparam int unsigned IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

    logic [HASH_W-1:0] hash_reg;
    logic [HASH_W-1:0] pos_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [LEN_W-1:0]  len_next;
    logic [LEN_W-1:0]  fin_len_reg;
    logic [CHAR_W-1:0] buf_reg [MAX_LEN];

    assign hash_next = hash_reg * HASH_MULT + HASH_W'(char_code) - CHAR_BASE + pos_reg;
    assign len_next  = (len_reg <= LEN_W'(MAX_LEN)) ? len_reg + LEN_W'(1) : len_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hash_reg    <= '0;
            pos_reg     <= '0;
            len_reg     <= '0;
            fin_len_reg <= '0;
        end else if (take) begin
            if (last) begin
                hash_reg    <= '0;
                pos_reg     <= '0;
                len_reg     <= '0;
                fin_len_reg <= len_next;
            end else begin
                hash_reg <= hash_next;
                pos_reg  <= pos_reg + HASH_W'(1);
                len_reg  <= len_next;
            end
        end
    end

    // hold characters past MAX_LEN out of the buffer
    always_ff @(posedge aclk) begin
        if (take && len_reg < LEN_W'(MAX_LEN)) begin
            buf_reg[len_reg[IDX_W-1:0]] <= char_code;
        end
    end

    always_comb begin
        for (int k = 0; k < MAX_LEN; k++) begin
            word_chars[k*CHAR_W +: CHAR_W] = buf_reg[k];
        end
    end

    assign fin_len = fin_len_reg;

endmodule

// File: rtl/khd_div.sv
`timescale 1ns / 1ps
module khd_div
    import khd_pkg::*;
#(
    parameter int unsigned TABLE_SIZE = 125,
    parameter int unsigned SLOT_W     = 7
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [HASH_W-1:0] dividend,
    output logic              done,
    output logic [SLOT_W-1:0] remainder
);
    // quotient by reciprocal multiplication, exact for every 32-bit dividend
    localparam int unsigned HALF_W   = HASH_W / 2;
    localparam int unsigned PROD_W   = HALF_W + HASH_W + 1;
    localparam int unsigned SUM_W    = 2 * HASH_W + 1;
    localparam int unsigned RECIP_SH = HASH_W + $clog2(TABLE_SIZE);
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << RECIP_SH) + 64'(TABLE_SIZE) - 64'd1) / 64'(TABLE_SIZE);
    localparam logic [HASH_W:0] RECIP = RECIP_FULL[HASH_W:0];

    logic [2:0]        vld_reg;
    logic              done_reg;
    logic [HASH_W-1:0] x_reg;
    logic [PROD_W-1:0] p_hi_reg;
    logic [PROD_W-1:0] p_lo_reg;
    logic [HASH_W-1:0] q_reg;
    logic [SLOT_W-1:0] rem_reg;
    logic [SUM_W-1:0]  sum;
    logic [SUM_W-1:0]  q_wide;
    logic [HASH_W-1:0] rem_full;

    assign sum      = {p_hi_reg, {HALF_W{1'b0}}} + SUM_W'(p_lo_reg);
    assign q_wide   = sum >> RECIP_SH;
    assign rem_full = x_reg - q_reg * HASH_W'(TABLE_SIZE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            vld_reg  <= {vld_reg[1:0], start};
            done_reg <= vld_reg[2];
        end
    end

    // stage one: partial products, stage two: quotient, stage three: remainder
    always_ff @(posedge aclk) begin
        if (start) begin
            x_reg <= dividend;
        end
        p_hi_reg <= x_reg[HASH_W-1:HALF_W] * RECIP;
        p_lo_reg <= x_reg[HALF_W-1:0] * RECIP;
        q_reg    <= q_wide[HASH_W-1:0];
        rem_reg  <= rem_full[SLOT_W-1:0];
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// File: rtl/khd_mem.sv
`timescale 1ns / 1ps
module khd_mem #(
    parameter int unsigned DEPTH  = 125,
    parameter int unsigned ADDR_W = 7,
    parameter int unsigned DATA_W = 150
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);
    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/keyword_hash_dictionary.sv
`timescale 1ns / 1ps
// Keyword dictionary: hash table with linear probing over whole words.
// Input channel (s_): one character per item, s_tlast on the final one.
// s_tuser carries the command (lookup, insert, clear); only the command and
// entry value on the last item count. Characters are taken one per cycle
// while s_tready is high. Result channel (m_): one item per word, found /
// value / slot / status. After the last character the block takes the
// remainder of the hash by TABLE_SIZE (reciprocal multiply in three
// pipeline stages), then probes slots, each with a memory read, then
// compare and write back, up to PROBE_LIMIT+1 probes, then moves the
// result into the output register. Clear sweeps the table.
// All slot state lives in one memory: used bit, length, value, characters.
// Reset: the block sweeps the table empty with s_tready low, then takes
// characters.
// Stall: a finished result waits in the output register; the next word's
// characters are still taken, and the block holds before loading the next
// result until the waiting one is taken.
module keyword_hash_dictionary
    import khd_pkg::*;
#(
    parameter int unsigned TABLE_SIZE  = 125,
    parameter int unsigned MAX_LEN     = 16,
    parameter int unsigned PROBE_LIMIT = 10
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // char_code[7:0], entry_value[23:8]
    input  logic [1:0]  s_tuser,   // command[1:0]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // found[0], result_value[16:1],
                                   // slot_index[23:17], status[25:24]
);
    localparam int unsigned SLOT_W  = $clog2(TABLE_SIZE);
    localparam int unsigned LEN_W   = $clog2(MAX_LEN + 2);
    localparam int unsigned PROBE_W = $clog2(PROBE_LIMIT + 1);
    localparam int unsigned ROW_W   = MAX_LEN * CHAR_W;
    localparam int unsigned MEM_W   = 1 + LEN_W + VALUE_W + ROW_W;

    state_t state_reg, state_next;

    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic [PROBE_W-1:0] probe_reg, probe_next;
    cmd_t               cmd_reg;
    logic [VALUE_W-1:0] val_reg;
    result_t            res_reg, res_next;
    logic               m_tvalid_reg;
    result_t            m_res_reg;

    logic               take;
    logic [HASH_W-1:0]  hash_next;
    logic [LEN_W-1:0]   fin_len;
    logic [ROW_W-1:0]   word_chars;
    logic               div_done;
    logic [SLOT_W-1:0]  home_slot;

    logic               wr_en;
    logic [MEM_W-1:0]   wr_data;
    logic [MEM_W-1:0]   rd_data;
    logic               rd_used;
    logic [LEN_W-1:0]   rd_len;
    logic [VALUE_W-1:0] rd_value;
    logic [ROW_W-1:0]   rd_chars;
    logic               chars_eq;
    logic               match;
    logic               too_long;
    logic               out_free;

    assign s_tready = (state_reg == S_IDLE);
    assign take     = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    khd_word #(
        .MAX_LEN (MAX_LEN),
        .LEN_W   (LEN_W)
    ) u_word (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .take       (take),
        .char_code  (s_tdata[7:0]),
        .last       (s_tlast),
        .hash_next  (hash_next),
        .fin_len    (fin_len),
        .word_chars (word_chars)
    );

    khd_div #(
        .TABLE_SIZE (TABLE_SIZE),
        .SLOT_W     (SLOT_W)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (take && s_tlast),
        .dividend  (hash_next),
        .done      (div_done),
        .remainder (home_slot)
    );

    khd_mem #(
        .DEPTH  (TABLE_SIZE),
        .ADDR_W (SLOT_W),
        .DATA_W (MEM_W)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (slot_reg),
        .wr_data (wr_data),
        .rd_addr (slot_reg),
        .rd_data (rd_data)
    );

    assign {rd_used, rd_len, rd_value, rd_chars} = rd_data;
    assign too_long = fin_len > LEN_W'(MAX_LEN);

    // compare only the characters that belong to the word
    always_comb begin
        chars_eq = 1'b1;
        for (int k = 0; k < MAX_LEN; k++) begin
            if (LEN_W'(k) < fin_len &&
                rd_chars[k*CHAR_W +: CHAR_W] != word_chars[k*CHAR_W +: CHAR_W]) begin
                chars_eq = 1'b0;
            end
        end
    end
    assign match = rd_used && (rd_len == fin_len) && chars_eq;

    always_comb begin
        state_next = state_reg;
        slot_next  = slot_reg;
        probe_next = probe_reg;
        res_next   = res_reg;
        wr_en      = 1'b0;
        wr_data    = '0;
        case (state_reg)
            S_INIT, S_WIPE: begin
                wr_en = 1'b1;
                if (slot_reg == SLOT_W'(TABLE_SIZE - 1)) begin
                    slot_next  = '0;
                    state_next = (state_reg == S_INIT) ? S_IDLE : S_RESP;
                end else begin
                    slot_next = slot_reg + SLOT_W'(1);
                end
            end
            S_IDLE: begin
                if (take && s_tlast) begin
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    res_next   = '0;
                    probe_next = '0;
                    if (cmd_reg == CMD_CLEAR) begin
                        slot_next  = '0;
                        state_next = S_WIPE;
                    end else if (too_long) begin
                        res_next.status = (cmd_reg == CMD_INSERT) ? ST_TOO_LONG : ST_NOT_FOUND;
                        state_next      = S_RESP;
                    end else begin
                        slot_next  = home_slot;
                        state_next = S_READ;
                    end
                end
            end
            S_READ: begin
                state_next = S_CHECK;
            end
            S_CHECK: begin
                if (!rd_used) begin
                    if (cmd_reg == CMD_INSERT) begin
                        wr_en         = 1'b1;
                        wr_data       = {1'b1, fin_len, val_reg, word_chars};
                        res_next.slot = SLOT_OUT_W'(slot_reg);
                    end else begin
                        res_next.status = ST_NOT_FOUND;
                    end
                    state_next = S_RESP;
                end else if (cmd_reg != CMD_INSERT && match) begin
                    res_next.found = 1'b1;
                    res_next.value = rd_value;
                    res_next.slot  = SLOT_OUT_W'(slot_reg);
                    state_next     = S_RESP;
                end else if (probe_reg == PROBE_W'(PROBE_LIMIT)) begin
                    res_next.status = (cmd_reg == CMD_INSERT) ? ST_NO_SLOT : ST_NOT_FOUND;
                    state_next      = S_RESP;
                end else begin
                    // advance to the next slot, wrapping at the table end
                    slot_next  = (slot_reg == SLOT_W'(TABLE_SIZE - 1)) ?
                                 '0 : slot_reg + SLOT_W'(1);
                    probe_next = probe_reg + PROBE_W'(1);
                    state_next = S_READ;
                end
            end
            S_RESP: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_INIT;
            slot_reg     <= '0;
            probe_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            slot_reg  <= slot_next;
            probe_reg <= probe_next;
            if (state_reg == S_RESP && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        res_reg <= res_next;
        if (take && s_tlast) begin
            cmd_reg <= s_tuser;
            val_reg <= s_tdata[23:8];
        end
        if (state_reg == S_RESP && out_free) begin
            m_res_reg <= res_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'd0, m_res_reg.status, m_res_reg.slot,
                       m_res_reg.value, m_res_reg.found};

endmodule
